// ----- hw/rtl/longest_window_with_target_sum_defines.svh -----
// assertion macros shared by the rtl files
`ifndef LONGEST_WINDOW_WITH_TARGET_SUM_DEFINES_SVH
`define LONGEST_WINDOW_WITH_TARGET_SUM_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define LWTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LWTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lwts_pkg.sv -----
package lwts_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int VALUE_W      = 16;
    localparam int TARGET_W     = 24;
    localparam int SUM_W        = TARGET_W + 1;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int BEST_W       = CNT_W;
    localparam int IN_TDATA_W   = ((VALUE_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W  = BEST_W + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic               rd_en;
        logic               clear;
        logic [VALUE_W-1:0] wr_data;
    } lwts_store_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] rd_data;
    } lwts_store_stat_t;

    typedef struct packed {
        logic [BEST_W-1:0] best_length;
        logic              window_hits_target;
        logic              window_overflow;
        logic              end_of_array;
    } lwts_result_t;

endpackage

// ----- hw/rtl/lwts_store.sv -----
`include "longest_window_with_target_sum_defines.svh"

module lwts_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lwts_pkg::lwts_store_cmd_t cmd,
    output lwts_pkg::lwts_store_stat_t stat
);
    import lwts_pkg::*;

    logic [VALUE_W-1:0] mem [WINDOW_DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [ADDR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  head_inc, tail_inc, rd_addr;

    assign head_inc = (head_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    // a pop in the same cycle moves the read to the entry behind the oldest
    assign rd_addr  = cmd.pop ? tail_inc : tail_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else begin
            if (cmd.push) begin
                head_next = head_inc;
            end
            if (cmd.pop) begin
                tail_next = tail_inc;
            end
            unique case ({cmd.push, cmd.pop})
                2'b10:   count_next = count_reg + 1'b1;
                2'b01:   count_next = count_reg - 1'b1;
                default: count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // writes and reads never share a cycle, so no bypass is needed
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[head_reg] <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stat.count   = count_reg;
    assign stat.rd_data = rd_data_reg;

    `LWTS_ASSERT_NOW(a_count_in_range, aclk, aresetn, 1'b1,
        count_reg <= CNT_W'(WINDOW_DEPTH), "window count above store depth")
    `LWTS_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, cmd.pop && !cmd.clear,
        count_reg != '0, "pop from an empty window")
    `LWTS_ASSERT_NOW(a_no_push_full, aclk, aresetn, cmd.push && !cmd.pop,
        count_reg != CNT_W'(WINDOW_DEPTH), "push into a full window without a drop")
    `LWTS_ASSERT_NOW(a_no_rd_wr_overlap, aclk, aresetn, cmd.push, !cmd.rd_en,
        "store read and write in the same cycle")

endmodule

// ----- hw/rtl/lwts_ctrl.sv -----
`include "longest_window_with_target_sum_defines.svh"

module lwts_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lwts_pkg::VALUE_W-1:0]  in_value,
    input  logic                          in_last,
    input  logic [lwts_pkg::TARGET_W-1:0] target,
    output lwts_pkg::lwts_store_cmd_t     store_cmd,
    input  lwts_pkg::lwts_store_stat_t    store_stat,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lwts_pkg::lwts_result_t        res
);
    import lwts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_CHECK,
        ST_POP,
        ST_FINAL
    } state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg, last_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [BEST_W-1:0]  best_reg, best_next;
    logic               ovf_reg, ovf_next;

    logic [SUM_W-1:0]   target_ext;
    logic [SUM_W-1:0]   sum_pop;
    logic [CNT_W-1:0]   cnt_pop;
    logic               hit;
    logic [BEST_W-1:0]  best_new;

    assign target_ext = {1'b0, target};
    assign sum_pop    = sum_reg - SUM_W'(store_stat.rd_data);
    assign cnt_pop    = store_stat.count - 1'b1;
    assign hit        = (sum_reg == target_ext);
    assign best_new   = (hit && (BEST_W'(store_stat.count) > best_reg))
                      ? BEST_W'(store_stat.count) : best_reg;

    assign in_ready = (state_reg == ST_IDLE);

    assign res.best_length        = best_new;
    assign res.window_hits_target = hit;
    assign res.window_overflow    = ovf_reg;
    assign res.end_of_array       = last_reg;

    always_comb begin
        state_next = state_reg;
        value_next = value_reg;
        last_next  = last_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        ovf_next   = ovf_reg;
        store_cmd         = '0;
        store_cmd.wr_data = value_reg;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    value_next = in_value;
                    last_next  = in_last;
                    if (store_stat.count == CNT_W'(WINDOW_DEPTH)) begin
                        // full: fetch the oldest entry before it is overwritten
                        store_cmd.rd_en = 1'b1;
                        state_next      = ST_DROP;
                    end else begin
                        store_cmd.push    = 1'b1;
                        store_cmd.wr_data = in_value;
                        sum_next          = sum_reg + SUM_W'(in_value);
                        state_next        = ST_CHECK;
                    end
                end
            end
            ST_DROP: begin
                store_cmd.pop  = 1'b1;
                store_cmd.push = 1'b1;
                sum_next   = sum_reg - SUM_W'(store_stat.rd_data) + SUM_W'(value_reg);
                ovf_next   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (store_stat.count != '0 && sum_reg > target_ext) begin
                    store_cmd.rd_en = 1'b1;
                    state_next      = ST_POP;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_POP: begin
                // one removal per cycle, next oldest fetched while this one retires
                store_cmd.pop = 1'b1;
                sum_next      = sum_pop;
                if (cnt_pop != '0 && sum_pop > target_ext) begin
                    store_cmd.rd_en = 1'b1;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    best_next  = best_new;
                    state_next = ST_IDLE;
                    if (last_reg) begin
                        store_cmd.clear = 1'b1;
                        sum_next        = '0;
                        best_next       = '0;
                        ovf_next        = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        last_reg  <= last_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            best_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            best_reg  <= best_next;
            ovf_reg   <= ovf_next;
        end
    end

    `LWTS_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, in_valid && in_ready,
        state_reg == ST_CHECK || state_reg == ST_DROP, "accepted beat did not start work")
    `LWTS_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, state_reg == ST_POP,
        store_stat.count != '0, "removal started on an empty window")
    `LWTS_ASSERT_NEXT(a_last_clears, aclk, aresetn, res_valid && res_ready && last_reg,
        sum_reg == '0 && best_reg == '0 && !ovf_reg, "state not cleared after last beat")

endmodule

// ----- hw/rtl/longest_window_with_target_sum.sv -----
// Longest window with a target sum over a stream of non-negative values, one array per
// run ended by s_tlast. Every input beat gives one result beat: best length so far, a hit
// flag for the current window, a sticky overflow flag (window passed the store depth and
// the oldest value was dropped) and m_tlast on the final answer; all state clears after
// it. An accepted beat is pushed into the window store or, when the window is full, the
// oldest value is read and then dropped as the new one is written; the sum is then checked
// and, while it exceeds the target, oldest values are removed, one removal per cycle, each
// reading the oldest entry; the result then goes to the output register, and the next beat
// can be accepted after that. The output register lets the next beat be accepted while a
// result waits. The store needs no clearing pass after reset. target_sum is written through
// cfg_wr_en / cfg_wr_data by the user only while the block is idle; it is not enforced.
module longest_window_with_target_sum (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lwts_pkg::TARGET_W-1:0]    cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lwts_pkg::IN_TDATA_W-1:0]  s_tdata,   // value
    input  logic                             s_tlast,   // last_of_array
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // best_length, window_hits_target, window_overflow, zero fill
    output logic [lwts_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast    // end_of_array
);
    import lwts_pkg::*;

    logic [TARGET_W-1:0] target_reg;
    lwts_store_cmd_t     store_cmd;
    lwts_store_stat_t    store_stat;
    logic                res_valid, res_ready;
    lwts_result_t        res;
    lwts_result_t        out_reg;
    logic                out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_wr_en) begin
            target_reg <= cfg_wr_data;
        end
    end

    lwts_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (store_cmd),
        .stat    (store_stat)
    );

    lwts_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata[VALUE_W-1:0]),
        .in_last    (s_tlast),
        .target     (target_reg),
        .store_cmd  (store_cmd),
        .store_stat (store_stat),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_reg.window_overflow, out_reg.window_hits_target,
                                    out_reg.best_length});
    assign m_tlast  = out_reg.end_of_array;

endmodule
